[design/escd_pkg.sv]
package escd_pkg;

    // Width of the internal byte counter; the reported length is capped at 16 bits.
    localparam int LENGTH_BITS = 16;

    // Depth of the queue between the classifier and the result stage.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // All results caused by one input character, in order.
    // Two results only occur when a numeric escape is ended by a character that
    // itself yields a result; the terminator is always the last result.
    typedef struct packed {
        logic [7:0] byte0;   // first result byte
        logic [7:0] byte1;   // second result byte, used when two is set
        logic       two;     // the item carries two results
        logic       term;    // the last result is the string terminator
    } escd_entry_t;

    // Caps a byte count to the 16-bit reported length.
    function automatic logic [15:0] sat_length(input logic [LENGTH_BITS-1:0] count);
        logic [LENGTH_BITS+15:0] wide;
        logic [15:0]             result;
        wide = {16'b0, count};
        if (wide > {{LENGTH_BITS{1'b0}}, 16'hFFFF})
        begin
            result = 16'hFFFF;
        end
        else
        begin
            result = wide[15:0];
        end
        return result;
    endfunction

endpackage

[design/escape_sequence_decoder.sv]
// Channel   Handshake                 Payload
// input     push / full               in_char
// result    empty / pop               out_char, run_last, string_end, out_length
//
// One character is accepted per cycle while full is low; an item that yields two
// results stays in the result stage until both have been popped, and the input
// is held whenever the four-entry queue is full, as a slow result side can cause.
// A result passes through the queue and then the result register before it can be popped.
// Reset is asynchronous and active low; it empties the queue and clears the decode
// state and the byte count. The two sides stall independently through the queue.
module escape_sequence_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_char,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_char,
    output logic        run_last,
    output logic        string_end,
    output logic [15:0] out_length
);

    // The front classifies each character against the escape state and packs every
    // result that the character causes into one queue entry. A character that only
    // changes state (a backslash, an x, a digit inside a run, an escaped newline)
    // pushes nothing.
    escd_pkg::escd_entry_t front_entry;
    logic                  front_push;

    // The queue decouples the classifier from the result stage.
    escd_pkg::escd_entry_t queue_entry;
    logic                  queue_empty;
    logic                  queue_pop;

    escd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .in_char    (in_char),
        .full       (full),
        .entry_push (front_push),
        .entry      (front_entry)
    );

    escd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_push),
        .push_entry (front_entry),
        .full       (full),
        .pop        (queue_pop),
        .pop_entry  (queue_entry),
        .empty      (queue_empty)
    );

    // The back end holds the oldest entry, hands out its results one at a time and
    // keeps the running byte count that is reported with the terminator.
    escd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (queue_empty),
        .fifo_entry (queue_entry),
        .fifo_pop   (queue_pop),
        .empty      (empty),
        .pop        (pop),
        .out_char   (out_char),
        .run_last   (run_last),
        .string_end (string_end),
        .out_length (out_length)
    );

endmodule

[design/escd_front.sv]
module escd_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [7:0]             in_char,
    input  logic                   full,
    output logic                   entry_push,
    output escd_pkg::escd_entry_t  entry
);

    typedef enum logic [1:0] {
        MODE_PLAIN,
        MODE_ESC,
        MODE_HEX,
        MODE_OCT
    } mode_t;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUESTION  = 8'h3F;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_B   = 8'h62;
    localparam logic [7:0] CH_LOWER_C   = 8'h63;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_V   = 8'h76;
    localparam logic [7:0] CH_LOWER_X   = 8'h78;
    localparam logic [7:0] CH_UPPER_X   = 8'h58;
    localparam logic [7:0] CH_DIGIT_0   = 8'h30;
    localparam logic [7:0] CH_DIGIT_7   = 8'h37;
    localparam logic [7:0] CH_DIGIT_9   = 8'h39;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_F   = 8'h46;

    localparam logic [7:0] CODE_BELL    = 8'h07;
    localparam logic [7:0] CODE_BS      = 8'h08;
    localparam logic [7:0] CODE_FS      = 8'h1C;
    localparam logic [7:0] CODE_FF      = 8'h0C;
    localparam logic [7:0] CODE_LF      = 8'h0A;
    localparam logic [7:0] CODE_TAB     = 8'h09;
    localparam logic [7:0] CODE_CR      = 8'h0D;
    localparam logic [7:0] CODE_VT      = 8'h0B;

    mode_t      mode_reg, mode_next;
    logic [1:0] digits_reg, digits_next;
    logic [7:0] accum_reg, accum_next;

    logic       accept;
    logic       hex_ok;
    logic [3:0] hex_digit;
    logic       oct_ok;

    assign accept = push && !full;

    always_comb
    begin
        hex_ok    = 1'b1;
        hex_digit = 4'd0;
        if (in_char >= CH_DIGIT_0 && in_char <= CH_DIGIT_9)
        begin
            hex_digit = 4'(in_char - CH_DIGIT_0);
        end
        else if (in_char >= CH_LOWER_A && in_char <= CH_LOWER_F)
        begin
            hex_digit = 4'(in_char - CH_LOWER_A + 8'd10);
        end
        else if (in_char >= CH_UPPER_A && in_char <= CH_UPPER_F)
        begin
            hex_digit = 4'(in_char - CH_UPPER_A + 8'd10);
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    assign oct_ok = (in_char >= CH_DIGIT_0) && (in_char <= CH_DIGIT_7);

    always_comb
    begin
        mode_next   = mode_reg;
        digits_next = digits_reg;
        accum_next  = accum_reg;
        entry_push  = 1'b0;
        entry       = '0;
        unique case (mode_reg)
            MODE_PLAIN:
            begin
                if (in_char == CH_NUL)
                begin
                    entry_push  = 1'b1;
                    entry.term  = 1'b1;
                    digits_next = 2'd0;
                    accum_next  = 8'd0;
                end
                else if (in_char == CH_BACKSLASH)
                begin
                    mode_next = MODE_ESC;
                end
                else
                begin
                    entry_push  = 1'b1;
                    entry.byte0 = in_char;
                end
            end
            MODE_ESC:
            begin
                mode_next  = MODE_PLAIN;
                entry_push = 1'b1;
                unique case (in_char)
                    CH_NUL:
                    begin
                        entry.term  = 1'b1;
                        digits_next = 2'd0;
                        accum_next  = 8'd0;
                    end
                    CH_LOWER_A:  entry.byte0 = CODE_BELL;
                    CH_LOWER_B:  entry.byte0 = CODE_BS;
                    CH_LOWER_C:  entry.byte0 = CODE_FS;
                    CH_LOWER_F:  entry.byte0 = CODE_FF;
                    CH_LOWER_N:  entry.byte0 = CODE_LF;
                    CH_LOWER_T:  entry.byte0 = CODE_TAB;
                    CH_LOWER_R:  entry.byte0 = CODE_CR;
                    CH_LOWER_V:  entry.byte0 = CODE_VT;
                    CH_QUESTION: entry.byte0 = CH_QUESTION;
                    CH_NEWLINE:  entry_push = 1'b0;
                    CH_LOWER_X, CH_UPPER_X:
                    begin
                        entry_push  = 1'b0;
                        mode_next   = MODE_HEX;
                        digits_next = 2'd0;
                        accum_next  = 8'd0;
                    end
                    default:
                    begin
                        if (oct_ok)
                        begin
                            entry_push  = 1'b0;
                            mode_next   = MODE_OCT;
                            digits_next = 2'd1;
                            accum_next  = {5'd0, in_char[2:0]};
                        end
                        else
                        begin
                            entry.byte0 = in_char;
                        end
                    end
                endcase
            end
            MODE_HEX, MODE_OCT:
            begin
                if ((mode_reg == MODE_HEX) ? hex_ok : oct_ok)
                begin
                    digits_next = digits_reg + 2'd1;
                    accum_next  = (mode_reg == MODE_HEX) ? {accum_reg[3:0], hex_digit}
                                                         : {accum_reg[4:0], in_char[2:0]};
                    if ((mode_reg == MODE_HEX) ? (digits_reg == 2'd1) : (digits_reg == 2'd2))
                    begin
                        entry_push  = 1'b1;
                        entry.byte0 = accum_next;
                        mode_next   = MODE_PLAIN;
                    end
                end
                else
                begin
                    // The run ends early: release its value, then treat the
                    // character as a fresh one.
                    entry_push  = 1'b1;
                    entry.byte0 = accum_reg;
                    mode_next   = MODE_PLAIN;
                    if (in_char == CH_NUL)
                    begin
                        entry.two   = 1'b1;
                        entry.term  = 1'b1;
                        digits_next = 2'd0;
                        accum_next  = 8'd0;
                    end
                    else if (in_char == CH_BACKSLASH)
                    begin
                        mode_next = MODE_ESC;
                    end
                    else
                    begin
                        entry.two   = 1'b1;
                        entry.byte1 = in_char;
                    end
                end
            end
            default:
            begin
                mode_next = MODE_PLAIN;
            end
        endcase
        if (!accept)
        begin
            entry_push = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_PLAIN;
            digits_reg <= 2'd0;
            accum_reg  <= 8'd0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            digits_reg <= digits_next;
            accum_reg  <= accum_next;
        end
    end

    // An octal run never holds more than two digits between characters.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_OCT) |-> (digits_reg == 2'd1 || digits_reg == 2'd2))
        else $error("octal run holds an impossible digit count");

endmodule

[design/escd_fifo.sv]
module escd_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  escd_pkg::escd_entry_t  push_entry,
    output logic                   full,
    input  logic                   pop,
    output escd_pkg::escd_entry_t  pop_entry,
    output logic                   empty
);

    escd_pkg::escd_entry_t entries_reg [escd_pkg::FIFO_DEPTH];

    logic [escd_pkg::FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [escd_pkg::FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [escd_pkg::FIFO_CNT_W-1:0] count_reg;

    logic do_push;
    logic do_pop;

    assign full      = (count_reg == escd_pkg::FIFO_CNT_W'(escd_pkg::FIFO_DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_entry = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == escd_pkg::FIFO_PTR_W'(escd_pkg::FIFO_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == escd_pkg::FIFO_PTR_W'(escd_pkg::FIFO_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("classifier pushed into a full queue");

endmodule

[design/escd_back.sv]
module escd_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fifo_empty,
    input  escd_pkg::escd_entry_t  fifo_entry,
    output logic                   fifo_pop,
    output logic                   empty,
    input  logic                   pop,
    output logic [7:0]             out_char,
    output logic                   run_last,
    output logic                   string_end,
    output logic [15:0]            out_length
);

    escd_pkg::escd_entry_t           entry_reg;
    logic                            valid_reg;
    logic                            phase_reg;
    logic [escd_pkg::LENGTH_BITS-1:0] count_reg;

    logic first_half;
    logic take;
    logic load;

    assign first_half = entry_reg.two && !phase_reg;
    assign take       = pop && valid_reg;
    assign load       = !valid_reg || (take && !first_half);
    assign fifo_pop   = load && !fifo_empty;
    assign empty      = !valid_reg;

    always_comb
    begin
        if (first_half)
        begin
            out_char   = entry_reg.byte0;
            run_last   = 1'b0;
            string_end = 1'b0;
        end
        else
        begin
            out_char   = entry_reg.two ? entry_reg.byte1 : entry_reg.byte0;
            run_last   = 1'b1;
            string_end = entry_reg.term;
        end
        out_length = string_end ? escd_pkg::sat_length(count_reg) : 16'd0;
    end

    always_ff @(posedge clk)
    begin
        if (fifo_pop)
        begin
            entry_reg <= fifo_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (take && first_half)
            begin
                phase_reg <= 1'b1;
            end
            else if (load)
            begin
                valid_reg <= !fifo_empty;
                phase_reg <= 1'b0;
            end
            if (take)
            begin
                if (string_end)
                begin
                    count_reg <= '0;
                end
                else if (count_reg != '1)
                begin
                    count_reg <= count_reg + {{(escd_pkg::LENGTH_BITS-1){1'b0}}, 1'b1};
                end
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (valid_reg && entry_reg.two))
        else $error("second result selected without a two-result item");

    assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(count_reg))
        else $error("byte count moved without a delivered result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !take) |=> ($stable(entry_reg) && $stable(phase_reg)))
        else $error("waiting result changed before it was taken");

endmodule
